FILE: rtl/ccv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccv_pkg
// Shared constants and types for the column consensus vote block.
// ----------------------------------------------------------------------------
package ccv_pkg;

    localparam int MAX_ROWS = 8;
    localparam int SYM_W    = 3;
    localparam int NUM_SYM  = 5;
    localparam int QUAL_W   = 8;
    localparam int LP_W     = 4;
    localparam int CNT_W    = $clog2(MAX_ROWS + 1);
    localparam int TIE_W    = $clog2(NUM_SYM + 1);
    localparam int SUM_W    = QUAL_W + $clog2(MAX_ROWS);
    localparam int CODES_W  = SYM_W * MAX_ROWS;
    localparam int QUALS_W  = QUAL_W * MAX_ROWS;

    localparam logic [SYM_W-1:0]  SYM_GAP       = 3'd4;
    localparam logic [QUAL_W-1:0] THRESH_AT_RST = 8'd43;

    typedef logic [NUM_SYM-1:0] t_onehot;

    typedef struct packed {
        logic             hit;
        logic [SYM_W-1:0] code;
    } t_decide;

endpackage

FILE: rtl/ccv_col_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccv_col_if
// Column channel: lane codes, lane qualities and lane count per item.
// ----------------------------------------------------------------------------
interface ccv_col_if import ccv_pkg::*; ();

    logic               valid;
    logic               ready;
    logic [CODES_W-1:0] base_codes;
    logic [QUALS_W-1:0] quality_bytes;
    logic [LP_W-1:0]    lanes_present;

    modport source (output valid, base_codes, quality_bytes, lanes_present, input ready);
    modport sink   (input valid, base_codes, quality_bytes, lanes_present, output ready);

endinterface

FILE: rtl/ccv_res_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccv_res_if
// Result channel: one consensus symbol per item.
// ----------------------------------------------------------------------------
interface ccv_res_if import ccv_pkg::*; ();

    logic             valid;
    logic             ready;
    logic [SYM_W-1:0] consensus_code;

    modport source (output valid, consensus_code, input ready);
    modport sink   (input valid, consensus_code, output ready);

endinterface

FILE: rtl/ccv_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccv_lane
// One lane: clamp the symbol code and register a one-hot vote and quality.
// ----------------------------------------------------------------------------
module ccv_lane import ccv_pkg::*; (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic              i_present,
    input  logic [SYM_W-1:0]  i_code,
    input  logic [QUAL_W-1:0] i_qual,
    output logic [SYM_W-1:0]  o_sym,
    output t_onehot           o_onehot,
    output logic [QUAL_W-1:0] o_qual
);

    t_onehot           r_onehot, n_onehot;
    logic [QUAL_W-1:0] r_qual;

    assign o_sym = (i_code > SYM_GAP) ? SYM_GAP : i_code;

    always_comb begin
        n_onehot = '0;
        if (i_present) begin
            n_onehot[o_sym] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_onehot <= n_onehot;
            r_qual   <= i_qual;
        end
    end

    assign o_onehot = r_onehot;
    assign o_qual   = r_qual;

endmodule

FILE: rtl/ccv_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccv_merge
// Combine lane votes: counts and sums, tie analysis, best sum, lane pick.
// ----------------------------------------------------------------------------
module ccv_merge import ccv_pkg::*; (
    input  logic                           i_clk,
    input  logic                           i_en,
    input  t_onehot [MAX_ROWS-1:0]         i_onehot,
    input  logic [MAX_ROWS-1:0][QUAL_W-1:0] i_qual,
    input  t_decide                        i_spec,
    output logic [SYM_W-1:0]               o_code
);

    // count and sum stage
    logic [NUM_SYM-1:0][CNT_W-1:0] r2_cnt, n2_cnt;
    logic [NUM_SYM-1:0][SUM_W-1:0] r2_sum, n2_sum;
    t_onehot [MAX_ROWS-1:0]        r2_oh;
    t_decide                       r2_dec;

    always_comb begin
        n2_cnt = '0;
        n2_sum = '0;
        for (int s = 0; s < NUM_SYM; s++) begin
            for (int i = 0; i < MAX_ROWS; i++) begin
                n2_cnt[s] = n2_cnt[s] + CNT_W'(i_onehot[i][s]);
                if (i_onehot[i][s]) begin
                    n2_sum[s] = n2_sum[s] + SUM_W'(i_qual[i]);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_cnt <= n2_cnt;
            r2_sum <= n2_sum;
            r2_oh  <= i_onehot;
            r2_dec <= i_spec;
        end
    end

    // tie stage
    logic [CNT_W-1:0]              largest;
    t_onehot                       n3_tied, r3_tied;
    logic [TIE_W-1:0]              tie_cnt;
    logic [SYM_W-1:0]              first_tied;
    t_decide                       n3_dec, r3_dec;
    logic [NUM_SYM-1:0][SUM_W-1:0] r3_sum;
    t_onehot [MAX_ROWS-1:0]        r3_oh;

    always_comb begin
        largest    = '0;
        tie_cnt    = '0;
        first_tied = SYM_GAP;
        for (int s = 0; s < NUM_SYM; s++) begin
            if (r2_cnt[s] > largest) begin
                largest = r2_cnt[s];
            end
        end
        for (int s = NUM_SYM - 1; s >= 0; s--) begin
            n3_tied[s] = (r2_cnt[s] == largest);
            if (n3_tied[s]) begin
                tie_cnt    = tie_cnt + 1'b1;
                first_tied = SYM_W'(s);
            end
        end
        n3_dec = r2_dec;
        if (!r2_dec.hit) begin
            if (tie_cnt == TIE_W'(1) || (tie_cnt == TIE_W'(2) && n3_tied[SYM_GAP])) begin
                n3_dec.hit  = 1'b1;
                n3_dec.code = first_tied;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_tied <= n3_tied;
            r3_dec  <= n3_dec;
            r3_sum  <= r2_sum;
            r3_oh   <= r2_oh;
        end
    end

    // best sum stage
    logic [SUM_W-1:0]              n4_best, r4_best;
    t_onehot                       r4_tied;
    t_decide                       r4_dec;
    logic [NUM_SYM-1:0][SUM_W-1:0] r4_sum;
    t_onehot [MAX_ROWS-1:0]        r4_oh;

    always_comb begin
        n4_best = '0;
        for (int s = 0; s < NUM_SYM; s++) begin
            if (r3_tied[s] && r3_sum[s] > n4_best) begin
                n4_best = r3_sum[s];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_best <= n4_best;
            r4_tied <= r3_tied;
            r4_dec  <= r3_dec;
            r4_sum  <= r3_sum;
            r4_oh   <= r3_oh;
        end
    end

    // lane pick stage
    t_onehot          win;
    logic [SYM_W-1:0] n5_code, r5_code;

    always_comb begin
        win = '0;
        for (int s = 0; s < NUM_SYM; s++) begin
            if (SYM_W'(s) != SYM_GAP) begin
                win[s] = r4_tied[s] && (r4_sum[s] == r4_best);
            end
        end
        n5_code = SYM_GAP;
        for (int i = MAX_ROWS - 1; i >= 0; i--) begin
            for (int s = 0; s < NUM_SYM; s++) begin
                if (r4_oh[i][s] && win[s]) begin
                    n5_code = SYM_W'(s);
                end
            end
        end
        if (r4_dec.hit) begin
            n5_code = r4_dec.code;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r5_code <= n5_code;
        end
    end

    assign o_code = r5_code;

endmodule

FILE: rtl/consensus_column_vote_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// consensus_column_vote_top
// Pipeline: the lane register loads at the accepting edge, then four merge
// stages follow (counts and sums, ties, best sum, lane pick); the lane pick
// register holds the result code.
// Throughput: one item per cycle; all stages advance together while the
// result register is empty or its item is taken.
// Reset: synchronous, active low; clears stage valids, threshold reads 43.
// ----------------------------------------------------------------------------
module consensus_column_vote_top import ccv_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    ccv_col_if.sink           i_col,
    ccv_res_if.source         o_res,
    input  logic              i_cfg_wr_en,
    input  logic [QUAL_W-1:0] i_cfg_wr_data
);

    localparam int NSTG = 5;

    logic [QUAL_W-1:0] r_thresh;
    logic [NSTG-1:0]   r_vld;
    logic              en;

    assign en          = !r_vld[NSTG-1] || o_res.ready;
    assign i_col.ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh <= THRESH_AT_RST;
        end else if (i_cfg_wr_en) begin
            r_thresh <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NSTG-2:0], i_col.valid};
        end
    end

    logic [LP_W-1:0]                 n_lanes;
    logic [MAX_ROWS-1:0][SYM_W-1:0]  lane_sym;
    t_onehot [MAX_ROWS-1:0]          lane_oh;
    logic [MAX_ROWS-1:0][QUAL_W-1:0] lane_q;

    assign n_lanes = (i_col.lanes_present > LP_W'(MAX_ROWS)) ? LP_W'(MAX_ROWS)
                                                             : i_col.lanes_present;

    for (genvar i = 0; i < MAX_ROWS; i++) begin : g_lane
        ccv_lane u_lane (
            .i_clk     (i_clk),
            .i_en      (en),
            .i_present (LP_W'(i) < n_lanes),
            .i_code    (i_col.base_codes[i*SYM_W +: SYM_W]),
            .i_qual    (i_col.quality_bytes[i*QUAL_W +: QUAL_W]),
            .o_sym     (lane_sym[i]),
            .o_onehot  (lane_oh[i]),
            .o_qual    (lane_q[i])
        );
    end

    // two-lane base against gap
    t_decide n_spec, r_spec;
    logic    gap0, gap1;

    assign gap0 = (lane_sym[0] == SYM_GAP);
    assign gap1 = (lane_sym[1] == SYM_GAP);

    always_comb begin
        n_spec = '{hit: 1'b0, code: SYM_GAP};
        if (n_lanes == LP_W'(2)) begin
            if (!gap0 && gap1) begin
                n_spec.hit = 1'b1;
                if (i_col.quality_bytes[QUAL_W-1:0] >= r_thresh) begin
                    n_spec.code = lane_sym[0];
                end
            end else if (gap0 && !gap1) begin
                n_spec.hit = 1'b1;
                if (i_col.quality_bytes[2*QUAL_W-1:QUAL_W] > r_thresh) begin
                    n_spec.code = lane_sym[1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_spec <= n_spec;
        end
    end

    ccv_merge u_merge (
        .i_clk    (i_clk),
        .i_en     (en),
        .i_onehot (lane_oh),
        .i_qual   (lane_q),
        .i_spec   (r_spec),
        .o_code   (o_res.consensus_code)
    );

    assign o_res.valid = r_vld[NSTG-1];

    a_code_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> (o_res.consensus_code <= SYM_GAP))
        else $error("consensus code out of range");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!en) |=> $stable(r_vld) && $stable(o_res.consensus_code))
        else $error("pipeline moved while stalled");

    a_cfg_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_wr_en |=> (r_thresh == $past(i_cfg_wr_data)))
        else $error("threshold write lost");

endmodule
